// ===== rtl/lbdh_pkg.sv =====
// ----------------------------------------------------------------------------
// Log-binned dual histogram package
// Shared constants for the histogram block.
// ----------------------------------------------------------------------------
`default_nettype none
package lbdh_pkg;
  localparam int unsigned NumBins = 64;
  localparam int unsigned AccW = 48;
  localparam int unsigned LogW = 21;
  localparam logic [1:0] ClsBinned = 2'd0;
  localparam logic [1:0] ClsUnder  = 2'd1;
  localparam logic [1:0] ClsOver   = 2'd2;
  localparam logic [2:0] RegDensMin = 3'd0;
  localparam logic [2:0] RegDensMax = 3'd1;
  localparam logic [2:0] RegDensBpo = 3'd2;
  localparam logic [2:0] RegEnMin   = 3'd3;
  localparam logic [2:0] RegEnMax   = 3'd4;
  localparam logic [2:0] RegEnBpo   = 3'd5;
  localparam logic [2:0] RegVolume  = 3'd6;
  localparam logic OpAccumulate = 1'b0;
  localparam logic OpRead       = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/lbdh_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module lbdh_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 66
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/lbdh_log2.sv =====
// ----------------------------------------------------------------------------
// Fixed-point log2 unit
// Iterative: msb search, then one mantissa squaring per cycle, each giving one fraction bit.
// ----------------------------------------------------------------------------
`default_nettype none
module lbdh_log2 (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [31:0]                x_i,
  output logic                            done_o,
  output logic      [lbdh_pkg::LogW-1:0]  log_o
);
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] m_q, m_d;
  logic [15:0] frac_q, frac_d;
  logic [4:0]  e_q, e_d;
  logic        done_q, done_d;
  logic [4:0]  msb;
  logic [65:0] sq;
  logic [34:0] sqs;

  always_comb begin
    msb = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (x_i[i]) msb = 5'(i);
    end
  end

  assign sq  = 66'(m_q) * 66'(m_q);
  assign sqs = sq[65:31];

  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q; m_d = m_q; frac_d = frac_q; e_d = e_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1; cnt_d = 5'd0; frac_d = 16'd0;
      e_d = msb;
      m_d = 33'({x_i, 31'd0} >> msb);
      if (x_i == 32'd0) begin
        e_d = 5'd0; m_d = 33'h80000000;
      end
    end else if (busy_q) begin
      if (sqs[34:32] != 3'd0) begin
        frac_d = {frac_q[14:0], 1'b1};
        m_d = sqs[33:1];
      end else begin
        frac_d = {frac_q[14:0], 1'b0};
        m_d = sqs[32:0];
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd15) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= 5'd0; done_q <= 1'b0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d; frac_q <= frac_d; e_q <= e_d;
  end

  assign done_o = done_q;
  assign log_o  = {e_q, frac_q};
endmodule
`default_nettype wire

// ===== rtl/log_binned_dual_histogram.sv =====
// ----------------------------------------------------------------------------
// Log-binned dual histogram
// Density and internal-energy histograms with logarithmic bins.
//
// Input words arrive on in_valid_i/in_ready_o with one field per port. An
// accumulate word (op 0) bins the cell density and its internal energy
// (total energy less half the squared speed, saturated) and adds cell_volume
// to one entry of each histogram unless skip_cell_i is set. A read word
// (op 1) returns one accumulator. Each input word gives one output word on
// out_valid_o/out_ready_i.
// An accumulate word passes one squared-speed step per velocity component,
// the internal-energy step, then per histogram two serial log2 runs
// (value, then minimum) and a bin step, then RAM read, write-back and output
// load. A read passes an address wait, RAM read, the write-back slot and
// output load; a skipped cell goes straight to output load. One word is in
// flight at a time; the next word is taken the cycle after the result is
// loaded.
// After reset all NUM_BINS+2 entries of both histograms are swept to zero,
// during which no input word is taken; configuration writes are always taken.
// When the receiver stalls the result is held in the output register; the
// next word is still taken and worked, and its result waits for the slot.
// ----------------------------------------------------------------------------
`default_nettype none
module log_binned_dual_histogram (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        op_i,
  input  wire logic        skip_cell_i,
  input  wire logic [31:0] density_i,
  input  wire logic signed [31:0] total_energy_i,
  input  wire logic signed [31:0] velocity_x_i,
  input  wire logic signed [31:0] velocity_y_i,
  input  wire logic signed [31:0] velocity_z_i,
  input  wire logic        read_which_i,
  input  wire logic [6:0]  read_entry_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       density_class_o,
  output logic [5:0]       density_bin_o,
  output logic [1:0]       energy_class_o,
  output logic [5:0]       energy_bin_o,
  output logic             counted_o,
  output logic [47:0]      read_value_o
);
  localparam int unsigned NUM_BINS = lbdh_pkg::NumBins;
  localparam int unsigned Depth = NUM_BINS + 2;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned AccW  = lbdh_pkg::AccW;
  localparam int unsigned LogW  = lbdh_pkg::LogW;

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StSq    = 4'd2;
  localparam logic [3:0] StEn    = 4'd3;
  localparam logic [3:0] StLogV  = 4'd4;
  localparam logic [3:0] StLogM  = 4'd5;
  localparam logic [3:0] StMul   = 4'd6;
  localparam logic [3:0] StRead  = 4'd7;
  localparam logic [3:0] StWrite = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;
  localparam logic [3:0] StRdWt  = 4'd10;

  logic [31:0] dmin_q, dmax_q, emin_q, emax_q, vol_q;
  logic [15:0] dbpo_q, ebpo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dmin_q <= 32'd65536; dmax_q <= 32'hFFFFFFFF; dbpo_q <= 16'd256;
      emin_q <= 32'd65536; emax_q <= 32'hFFFFFFFF; ebpo_q <= 16'd256;
      vol_q  <= 32'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lbdh_pkg::RegDensMin: dmin_q <= cfg_wdata_i;
        lbdh_pkg::RegDensMax: dmax_q <= cfg_wdata_i;
        lbdh_pkg::RegDensBpo: dbpo_q <= cfg_wdata_i[15:0];
        lbdh_pkg::RegEnMin:   emin_q <= cfg_wdata_i;
        lbdh_pkg::RegEnMax:   emax_q <= cfg_wdata_i;
        lbdh_pkg::RegEnBpo:   ebpo_q <= cfg_wdata_i[15:0];
        lbdh_pkg::RegVolume:  vol_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [3:0]  st_q, st_d;
  logic [AW:0] clr_q, clr_d;
  logic        side_q, side_d;
  logic [2:0]  sqi_q, sqi_d;
  logic        op_q, skip_q, which_q;
  logic [6:0]  entry_q;
  logic [31:0] dens_q, vx_q, vy_q, vz_q;
  logic signed [31:0] te_q;
  logic [65:0] sq_q, sq_d;
  logic [31:0] ev_q, ev_d;
  logic        eneg_q, eneg_d;
  logic [LogW-1:0] lv_q, lv_d;
  logic [39:0] prod_q, prod_d;
  logic [1:0]  dcls_q, dcls_d, ecls_q, ecls_d;
  logic [5:0]  dbin_q, dbin_d, ebin_q, ebin_d;
  logic [AW-1:0] didx_q, didx_d, eidx_q, eidx_d;
  logic        ov_q, ov_d;
  logic [1:0]  o_dc_q, o_ec_q;
  logic [5:0]  o_db_q, o_eb_q;
  logic        o_cnt_q;
  logic [AccW-1:0] o_rv_q;

  logic        load;
  logic [31:0] vsel, vsq_src;
  logic [63:0] vsq;
  logic        lg_start, lg_done;
  logic [31:0] lg_x;
  logic [LogW-1:0] lg_out;
  logic        we_d, we_e;
  logic [AW-1:0] waddr, raddr_d, raddr_e;
  logic [AccW-1:0] wd_d, wd_e, rd_d, rd_e;
  logic [AccW-1:0] rv_d;
  logic        o_load;
  logic [31:0] cur_v, cur_mn, cur_mx;
  logic [15:0] cur_bpo;
  logic        cur_neg;
  logic [LogW-1:0] ldiff;
  logic signed [50:0] en_full;
  logic [1:0]  ccls;
  logic [AW-1:0] cidx;
  logic [39:0] bsh;
  logic [5:0]  cbin;

  assign load = in_valid_i && in_ready_o;
  assign in_ready_o = (st_q == StIdle);

  always_comb begin
    case (sqi_q)
      3'd0: vsel = vx_q;
      3'd1: vsel = vy_q;
      default: vsel = vz_q;
    endcase
  end
  assign vsq_src = vsel[31] ? (~vsel + 32'd1) : vsel;
  assign vsq = 64'(vsq_src) * 64'(vsq_src);
  assign en_full = 51'(te_q) - 51'(sq_q[65:17]);

  assign cur_v   = side_q ? ev_q : dens_q;
  assign cur_neg = side_q ? eneg_q : 1'b0;
  assign cur_mn  = side_q ? emin_q : dmin_q;
  assign cur_mx  = side_q ? emax_q : dmax_q;
  assign cur_bpo = side_q ? ebpo_q : dbpo_q;
  assign ldiff   = (lv_q > lg_out) ? (lv_q - lg_out) : '0;
  assign lg_x    = (st_q == StLogV) ? cur_mn : ((st_q == StMul) ? ev_q : dens_q);

  always_comb begin
    if (cur_neg || cur_v < cur_mn) begin
      ccls = lbdh_pkg::ClsUnder; cidx = AW'(NUM_BINS);
    end else if (cur_v > cur_mx) begin
      ccls = lbdh_pkg::ClsOver;  cidx = AW'(NUM_BINS + 1);
    end else begin
      ccls = lbdh_pkg::ClsBinned;
      bsh = prod_q >> 24;
      cidx = (bsh > 40'(NUM_BINS - 1)) ? AW'(NUM_BINS - 1) : AW'(bsh);
    end
    bsh  = prod_q >> 24;
    cbin = (ccls == lbdh_pkg::ClsBinned) ? 6'(cidx) : 6'd0;
  end

  lbdh_log2 u_log2 (
    .clk_i, .rst_ni, .start_i(lg_start), .x_i(lg_x),
    .done_o(lg_done), .log_o(lg_out)
  );

  always_comb begin
    st_d = st_q; clr_d = clr_q; side_d = side_q; sqi_d = sqi_q;
    sq_d = sq_q; ev_d = ev_q; eneg_d = eneg_q; lv_d = lv_q; prod_d = prod_q;
    dcls_d = dcls_q; ecls_d = ecls_q; dbin_d = dbin_q; ebin_d = ebin_q;
    didx_d = didx_q; eidx_d = eidx_q;
    ov_d = ov_q; o_load = 1'b0; rv_d = '0;
    lg_start = 1'b0;
    we_d = 1'b0; we_e = 1'b0; waddr = clr_q[AW-1:0];
    wd_d = '0; wd_e = '0;
    raddr_d = didx_q; raddr_e = eidx_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (st_q)
      StClear: begin
        we_d = 1'b1; we_e = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == (AW+1)'(Depth - 1)) st_d = StIdle;
      end
      StIdle: begin
        if (load) begin
          sqi_d = 3'd0; sq_d = '0; side_d = 1'b0;
          dcls_d = '0; ecls_d = '0; dbin_d = '0; ebin_d = '0;
          if (op_i == lbdh_pkg::OpRead) st_d = StRdWt;
          else if (skip_cell_i) st_d = StOut;
          else st_d = StSq;
        end
      end
      StRdWt: begin
        raddr_d = entry_q[AW-1:0]; raddr_e = entry_q[AW-1:0];
        st_d = StRead;
      end
      StSq: begin
        sq_d = sq_q + 66'(vsq);
        sqi_d = sqi_q + 3'd1;
        if (sqi_q == 3'd2) st_d = StEn;
      end
      StEn: begin
        if (en_full < -51'sd2147483648) begin
          eneg_d = 1'b1; ev_d = '0;
        end else if (en_full < 0) begin
          eneg_d = 1'b1; ev_d = '0;
        end else if (en_full > 51'sd2147483647) begin
          eneg_d = 1'b0; ev_d = 32'h7FFFFFFF;
        end else begin
          eneg_d = 1'b0; ev_d = en_full[31:0];
        end
        lg_start = 1'b1; st_d = StLogV;
      end
      StLogV: begin
        if (lg_done) begin
          lv_d = lg_out; lg_start = 1'b1; st_d = StLogM;
        end
      end
      StLogM: begin
        if (lg_done) begin
          prod_d = 40'(ldiff) * 40'(cur_bpo);
          st_d = StMul;
        end
      end
      StMul: begin
        if (!side_q) begin
          dcls_d = ccls; dbin_d = cbin; didx_d = cidx;
          side_d = 1'b1; lg_start = 1'b1; st_d = StLogV;
        end else begin
          ecls_d = ccls; ebin_d = cbin; eidx_d = cidx;
          st_d = StRead;
        end
      end
      StRead: begin
        st_d = StWrite;
      end
      StWrite: begin
        if (op_q == lbdh_pkg::OpAccumulate) begin
          we_d = 1'b1; we_e = 1'b1;
        end
        st_d = StOut;
      end
      StOut: begin
        if (!ov_q || out_ready_i) begin
          o_load = 1'b1; ov_d = 1'b1; st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
    if (st_q == StWrite) begin
      wd_d = rd_d + AccW'(vol_q);
      wd_e = rd_e + AccW'(vol_q);
    end
    if (st_q == StRead || st_q == StWrite || st_q == StOut) begin
      if (op_q == lbdh_pkg::OpRead) begin
        raddr_d = entry_q[AW-1:0]; raddr_e = entry_q[AW-1:0];
      end
    end
    if (op_q == lbdh_pkg::OpRead && 32'(entry_q) < Depth) begin
      rv_d = which_q ? rd_e : rd_d;
    end
  end

  lbdh_ram #(.Width(AccW), .Depth(Depth)) u_dens_ram (
    .clk_i, .we_i(we_d), .waddr_i((st_q == StClear) ? waddr : didx_q),
    .wdata_i(wd_d), .raddr_i(raddr_d), .rdata_o(rd_d)
  );
  lbdh_ram #(.Width(AccW), .Depth(Depth)) u_en_ram (
    .clk_i, .we_i(we_e), .waddr_i((st_q == StClear) ? waddr : eidx_q),
    .wdata_i(wd_e), .raddr_i(raddr_e), .rdata_o(rd_e)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; clr_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_d; sqi_q <= sqi_d; sq_q <= sq_d; ev_q <= ev_d;
    eneg_q <= eneg_d; lv_q <= lv_d; prod_q <= prod_d;
    dcls_q <= dcls_d; ecls_q <= ecls_d; dbin_q <= dbin_d; ebin_q <= ebin_d;
    didx_q <= didx_d; eidx_q <= eidx_d;
    if (load) begin
      op_q <= op_i; skip_q <= skip_cell_i; which_q <= read_which_i;
      entry_q <= read_entry_i; dens_q <= density_i; te_q <= total_energy_i;
      vx_q <= velocity_x_i; vy_q <= velocity_y_i; vz_q <= velocity_z_i;
    end
    if (o_load) begin
      o_dc_q <= dcls_q; o_ec_q <= ecls_q; o_db_q <= dbin_q; o_eb_q <= ebin_q;
      o_cnt_q <= (op_q == lbdh_pkg::OpAccumulate) && !skip_q;
      o_rv_q <= rv_d;
    end
  end

  assign out_valid_o     = ov_q;
  assign density_class_o = o_dc_q;
  assign density_bin_o   = o_db_q;
  assign energy_class_o  = o_ec_q;
  assign energy_bin_o    = o_eb_q;
  assign counted_o       = o_cnt_q;
  assign read_value_o    = o_rv_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> !in_ready_o) else $error("accept while busy");
  a_clear_no_write_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StClear) |-> !out_valid_o) else $error("output during clear");
  a_out_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_load |=> out_valid_o) else $error("result lost");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_d && st_q != StClear) |-> (st_q == StWrite)) else $error("stray write");
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Log-binned dual histogram testbench
// Drives cell and read words through the histogram block, predicts each
// result from an internal model of the bin arithmetic and accumulators, and
// compares field by field with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  localparam int unsigned NBins = lbdh_pkg::NumBins;
  localparam int unsigned Depth = NBins + 2;

  typedef struct packed {
    logic        op;
    logic        skip;
    logic [31:0] dens;
    logic [31:0] te;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic        which;
    logic [6:0]  entry;
  } cell_word_t;

  typedef struct packed {
    logic [1:0]  dcls;
    logic [5:0]  dbin;
    logic [1:0]  ecls;
    logic [5:0]  ebin;
    logic        cnt;
    logic [47:0] rv;
  } bin_word_t;

  typedef struct {
    cell_word_t w;
    logic       has_exp;
    bin_word_t  exp;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  cell_word_t  drv = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  density_class_o;
  logic [5:0]  density_bin_o;
  logic [1:0]  energy_class_o;
  logic [5:0]  energy_bin_o;
  logic        counted_o;
  logic [47:0] read_value_o;

  log_binned_dual_histogram u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o,
    .op_i(drv.op), .skip_cell_i(drv.skip), .density_i(drv.dens),
    .total_energy_i(drv.te), .velocity_x_i(drv.vx), .velocity_y_i(drv.vy),
    .velocity_z_i(drv.vz), .read_which_i(drv.which), .read_entry_i(drv.entry),
    .out_valid_o, .out_ready_i,
    .density_class_o, .density_bin_o, .energy_class_o, .energy_bin_o,
    .counted_o, .read_value_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // shadow state
  logic [31:0] dens_min, dens_max, en_min, en_max, volume;
  logic [15:0] dens_bpo, en_bpo;
  logic [47:0] dens_hist [Depth];
  logic [47:0] en_hist [Depth];

  bin_word_t expected_bins[$];
  int unsigned mismatches = 0;
  bit          hold_off = 1'b0;

  function automatic logic [21:0] log2_fx(logic [31:0] x);
    int unsigned e;
    logic [63:0] m;
    logic [15:0] frac;
    e = 0;
    frac = '0;
    if (x == 0) return '0;
    for (int i = 31; i >= 0; i--) begin
      if (x[i]) begin
        e = i;
        break;
      end
    end
    m = 64'(x) << (31 - e);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return {e[5:0], frac};
  endfunction

  function automatic void bin_value(input logic [31:0] v, input logic neg,
                                    input logic [31:0] mn, input logic [31:0] mx,
                                    input logic [15:0] bpo, output logic [1:0] cls,
                                    output logic [5:0] bin, output int unsigned idx);
    logic [63:0] lv, lm, b;
    bin = '0;
    if (neg || v < mn) begin
      cls = lbdh_pkg::ClsUnder;
      idx = NBins;
    end else if (v > mx) begin
      cls = lbdh_pkg::ClsOver;
      idx = NBins + 1;
    end else begin
      cls = lbdh_pkg::ClsBinned;
      lv = 64'(log2_fx(v));
      lm = 64'(log2_fx(mn));
      b = (lv > lm) ? (((lv - lm) * 64'(bpo)) >> 24) : 64'd0;
      if (b > 64'(NBins - 1)) b = 64'(NBins - 1);
      idx = 32'(b);
      bin = b[5:0];
    end
  endfunction

  function automatic bin_word_t predict_bins(cell_word_t w);
    bin_word_t r;
    longint signed vx, vy, vz, en;
    logic [63:0] sq;
    int unsigned di, ei;
    r = '0;
    if (w.op == lbdh_pkg::OpRead) begin
      if (w.entry < Depth) r.rv = w.which ? en_hist[w.entry] : dens_hist[w.entry];
    end else if (!w.skip) begin
      vx = longint'($signed(w.vx));
      vy = longint'($signed(w.vy));
      vz = longint'($signed(w.vz));
      sq = 64'(vx * vx) + 64'(vy * vy) + 64'(vz * vz);
      en = longint'($signed(w.te)) - longint'(sq >> 17);
      if (en < -64'sd2147483648) en = -64'sd2147483648;
      if (en > 64'sd2147483647) en = 64'sd2147483647;
      bin_value(w.dens, 1'b0, dens_min, dens_max, dens_bpo, r.dcls, r.dbin, di);
      bin_value((en < 0) ? 32'd0 : en[31:0], en < 0, en_min, en_max, en_bpo,
                r.ecls, r.ebin, ei);
      dens_hist[di] = dens_hist[di] + 48'(volume);
      en_hist[ei] = en_hist[ei] + 48'(volume);
      r.cnt = 1'b1;
    end
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      lbdh_pkg::RegDensMin: dens_min = val;
      lbdh_pkg::RegDensMax: dens_max = val;
      lbdh_pkg::RegDensBpo: dens_bpo = val[15:0];
      lbdh_pkg::RegEnMin:   en_min = val;
      lbdh_pkg::RegEnMax:   en_max = val;
      lbdh_pkg::RegEnBpo:   en_bpo = val[15:0];
      lbdh_pkg::RegVolume:  volume = val;
      default: ;
    endcase
  endtask

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_word(cell_word_t w, logic has_exp, bin_word_t exp);
    bin_word_t p;
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    drv <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    p = predict_bins(w);
    expected_bins.push_back(has_exp ? exp : p);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_speed();
    case ($urandom_range(3))
      0: return 32'($signed($urandom_range(2000, 0)) - 1000) <<< 8;
      1: return $urandom;
      default: return 32'($signed($urandom_range(600, 0)) - 300) <<< 10;
    endcase
  endfunction

  function automatic cell_word_t rnd_cell();
    cell_word_t w;
    w = '0;
    w.op = ($urandom_range(9) == 0) ? lbdh_pkg::OpRead : lbdh_pkg::OpAccumulate;
    w.skip = ($urandom_range(9) == 0);
    case ($urandom_range(3))
      0: w.dens = $urandom;
      1: w.dens = $urandom_range(32'h0080_0000, 0);
      default: w.dens = 32'h1 << $urandom_range(31);
    endcase
    w.dens = w.dens ^ ($urandom_range(1) ? $urandom_range(255) : 0);
    w.te = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0400_0000, 0);
    w.vx = rnd_speed();
    w.vy = rnd_speed();
    w.vz = rnd_speed();
    w.which = $urandom_range(1);
    w.entry = ($urandom_range(19) == 0) ? 7'($urandom) : 7'($urandom_range(Depth - 1));
    return w;
  endfunction

  task automatic read_all();
    cell_word_t w;
    w = '0;
    w.op = lbdh_pkg::OpRead;
    for (int h = 0; h < 2; h++) begin
      for (int e = 0; e < Depth; e++) begin
        w.which = h[0];
        w.entry = e[6:0];
        send_word(w, 1'b0, '0);
      end
    end
  endtask

  // checker
  always @(posedge clk_i) begin
    bin_word_t got, exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{density_class_o, density_bin_o, energy_class_o, energy_bin_o,
              counted_o, read_value_o};
      if (expected_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        exp = expected_bins.pop_front();
        if (got !== exp) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp dc%0d db%0d ec%0d eb%0d c%0d rv%h",
                      " / got dc%0d db%0d ec%0d eb%0d c%0d rv%h"},
                     exp.dcls, exp.dbin, exp.ecls, exp.ebin, exp.cnt, exp.rv,
                     got.dcls, got.dbin, got.ecls, got.ebin, got.cnt, got.rv);
        end
      end
    end
  end

  // receiver
  initial begin
    int unsigned g;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      g = gap_len();
      if (g != 0) begin
        out_ready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    cell_word_t w;
    dens_min = 32'd65536; dens_max = '1; dens_bpo = 16'd256;
    en_min = 32'd65536; en_max = '1; en_bpo = 16'd256;
    volume = 32'd1;
    for (int i = 0; i < Depth; i++) begin
      dens_hist[i] = '0;
      en_hist[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reads after reset, extremes, skip, negative energy, overflow
    w = '0; w.op = lbdh_pkg::OpRead; w.entry = 7'd0;
    r = '{w, 1'b1, '0}; rows.push_back(r);
    w.entry = 7'd65; w.which = 1'b1; r = '{w, 1'b1, '0}; rows.push_back(r);
    w.entry = 7'd127; r = '{w, 1'b1, '0}; rows.push_back(r);
    w = '0; w.dens = '1; w.te = 32'h7FFF_FFFF;
    r = '{w, 1'b1, '{lbdh_pkg::ClsBinned, 6'd15, lbdh_pkg::ClsBinned, 6'd14, 1'b1, 48'd0}};
    rows.push_back(r);
    w = '0; w.skip = 1'b1; w.dens = '1; w.te = '1; w.vx = '1; w.vy = '1; w.vz = '1;
    w.which = 1'b1; w.entry = '1;
    r = '{w, 1'b1, '0}; rows.push_back(r);
    w = '0; w.dens = 32'd0; w.te = 32'h8000_0000;
    r = '{w, 1'b1, '{lbdh_pkg::ClsUnder, 6'd0, lbdh_pkg::ClsUnder, 6'd0, 1'b1, 48'd0}};
    rows.push_back(r);
    w = '0; w.dens = 32'h0001_0000; w.te = 32'h0001_0000;
    r = '{w, 1'b1, '{lbdh_pkg::ClsBinned, 6'd0, lbdh_pkg::ClsBinned, 6'd0, 1'b1, 48'd0}};
    rows.push_back(r);
    w = '0; w.dens = 32'h0002_0000; w.te = 32'h7FFF_FFFF;
    w.vx = 32'h8000_0000; w.vy = 32'h8000_0000; w.vz = 32'h8000_0000;
    rows.push_back('{w, 1'b0, '0});
    w.vx = 32'h7FFF_FFFF; w.vy = 32'h0; w.vz = 32'h0001_8000;
    rows.push_back('{w, 1'b0, '0});
    w = '0; w.dens = 32'h00FF_FFFF; w.te = 32'h0400_0000; w.vx = 32'h0002_0000;
    rows.push_back('{w, 1'b0, '0});
    foreach (rows[i]) send_word(rows[i].w, rows[i].has_exp, rows[i].exp);
    read_all();
    drain();

    // settings, extremes among them
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(lbdh_pkg::RegDensMin, 32'h0000_4000);
          write_reg(lbdh_pkg::RegDensMax, 32'h0100_0000);
          write_reg(lbdh_pkg::RegDensBpo, 16'd2048);
          write_reg(lbdh_pkg::RegEnMin, 32'h0000_1000);
          write_reg(lbdh_pkg::RegEnMax, 32'h0200_0000);
          write_reg(lbdh_pkg::RegEnBpo, 16'd1024);
          write_reg(lbdh_pkg::RegVolume, 32'd3);
        end
        1: begin
          write_reg(lbdh_pkg::RegDensMin, 32'd1);
          write_reg(lbdh_pkg::RegDensMax, 32'd1);
          write_reg(lbdh_pkg::RegDensBpo, 16'hFFFF);
          write_reg(lbdh_pkg::RegEnMin, 32'hFFFF_FFFF);
          write_reg(lbdh_pkg::RegEnMax, 32'hFFFF_FFFF);
          write_reg(lbdh_pkg::RegEnBpo, 16'd1);
          write_reg(lbdh_pkg::RegVolume, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(lbdh_pkg::RegDensMin, 32'h0100_0000);
          write_reg(lbdh_pkg::RegDensMax, 32'h0000_1000);
          write_reg(lbdh_pkg::RegDensBpo, 16'd0);
          write_reg(lbdh_pkg::RegEnMin, 32'd0);
          write_reg(lbdh_pkg::RegEnMax, 32'h0100_0000);
          write_reg(lbdh_pkg::RegEnBpo, 16'd0);
          write_reg(lbdh_pkg::RegVolume, 32'd0);
        end
        3: begin
          write_reg(lbdh_pkg::RegDensMin, 32'd0);
          write_reg(lbdh_pkg::RegDensMax, 32'hFFFF_FFFF);
          write_reg(lbdh_pkg::RegDensBpo, 16'd512);
          write_reg(lbdh_pkg::RegEnMin, 32'd1);
          write_reg(lbdh_pkg::RegEnMax, 32'h7FFF_FFFF);
          write_reg(lbdh_pkg::RegEnBpo, 16'd768);
          write_reg(lbdh_pkg::RegVolume, $urandom);
        end
        default: begin
          write_reg(lbdh_pkg::RegDensMin, $urandom_range(32'h0010_0000, 1));
          write_reg(lbdh_pkg::RegDensMax, $urandom_range(32'hFFFF_FFFF, 32'h0100_0000));
          write_reg(lbdh_pkg::RegDensBpo, $urandom_range(65535, 1));
          write_reg(lbdh_pkg::RegEnMin, $urandom_range(32'h0010_0000, 1));
          write_reg(lbdh_pkg::RegEnMax, $urandom);
          write_reg(lbdh_pkg::RegEnBpo, $urandom_range(4096, 1));
          write_reg(lbdh_pkg::RegVolume, $urandom_range(1000));
        end
      endcase
      cfg_we_i <= 1'b0;
      for (int i = 0; i < 140; i++) begin
        if (phase == 1 && i == 20) hold_off = 1'b1;
        send_word(rnd_cell(), 1'b0, '0);
      end
      read_all();
      drain();
    end

    if (mismatches == 0 && expected_bins.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
